/* hw/rtl/vsft_pkg.sv */
// Package of shared constants, types and helper functions for the viscous stencil force term.
`timescale 1ns / 1ps
package vsft_pkg;
    localparam int MAX_DEPTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 31;

    localparam logic [CFG_IDX_W-1:0] REG_VISCOSITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DX2   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DZ2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd6;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    // Clip a wide signed value to the 32-bit range, reporting whether it was clipped.
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] res;
        if (v > Q_MAX) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < Q_MIN) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    // Item handed from the front part to the back part: centre values and neighbours.
    typedef struct packed {
        logic signed [31:0] force_v;
        logic signed [31:0] grad_v;
        logic [30:0]        perm_v;
        logic signed [31:0] vel_c;
        logic signed [31:0] vel_n;
        logic signed [31:0] vel_p;
        logic signed [31:0] eta_n;
        logic signed [31:0] eta_c;
        logic signed [31:0] eta_p;
        logic signed [31:0] zeta_n;
        logic signed [31:0] zeta_c;
        logic signed [31:0] zeta_p;
        logic [21:0]        index;
        logic               last;
    } t_work;
endpackage

/* hw/rtl/vsft_front.sv */
// Front part: walks the grid, keeps the plane buffers and gathers each interior stencil.
`timescale 1ns / 1ps
module vsft_front #(
    parameter int MAX_DEPTH  = vsft_pkg::MAX_DEPTH_DEF,
    parameter int MAX_HEIGHT = vsft_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = vsft_pkg::MAX_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_restart,
    input  logic [10:0]        i_depth,
    input  logic [6:0]         i_height,
    input  logic [6:0]         i_width,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_force_req,
    input  logic signed [31:0] i_pressure_grad,
    input  logic [30:0]        i_permeability,
    input  logic signed [31:0] i_eta_val,
    input  logic signed [31:0] i_zeta_val,
    input  logic signed [31:0] i_velocity,
    output logic               o_valid,
    input  logic               i_stall,
    output vsft_pkg::t_work    o_work
);
    localparam int PW = $clog2(MAX_DEPTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = RW + CW;
    localparam int WORDS = 1 << AW;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int MAX_WIDTH_P2 = 1 << CW;

    typedef enum logic [1:0] {S_IDLE, S_R0, S_R1, S_OUT} t_state;

    // Two banks swap roles at each plane: one is written with the incoming plane,
    // the other holds the centre plane. A third eta bank holds the back plane.
    logic signed [31:0] r_eta   [3][WORDS];
    logic signed [31:0] r_force [2][WORDS];
    logic signed [31:0] r_grad  [2][WORDS];
    logic [30:0]        r_perm  [2][WORDS];
    logic signed [31:0] r_zeta  [2][WORDS];
    logic signed [31:0] r_vel   [2][WORDS];

    t_state r_state;
    logic [PW-1:0] r_p;
    logic [RW-1:0] r_r;
    logic [CW-1:0] r_c;
    logic          r_nb;
    logic [1:0]    r_eta_nb;
    logic [1:0]    r_eta_cb;
    logic [1:0]    r_eta_bb;
    logic [AW-1:0] r_pos;
    logic [21:0]   r_index;
    logic          r_last;
    logic signed [31:0] r_eta_in;
    vsft_pkg::t_work r_work;
    logic signed [31:0] r_rd_a, r_rd_b, r_rd_c, r_rd_d, r_rd_e, r_rd_f;
    logic [30:0]        r_rd_k;

    logic [DW-1:0] dep;
    logic [HW-1:0] hgt;
    logic [WW-1:0] wid;
    logic [DW-1:0] p_w;
    logic [HW-1:0] r_w;
    logic [WW-1:0] c_w;
    logic          interior;
    logic [AW-1:0] pos;
    logic          accept;
    logic          end_row, end_plane, end_grid;
    logic [31:0]   idx_full;

    always_comb begin
        dep = (i_depth < 11'd3) ? DW'(3) : ((32'(i_depth) > MAX_DEPTH) ? DW'(MAX_DEPTH)
              : DW'(i_depth));
        hgt = (i_height < 7'd3) ? HW'(3) : ((32'(i_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT)
              : HW'(i_height));
        wid = (i_width < 7'd3) ? WW'(3) : ((32'(i_width) > MAX_WIDTH) ? WW'(MAX_WIDTH)
              : WW'(i_width));
        p_w = DW'(r_p);
        r_w = HW'(r_r);
        c_w = WW'(r_c);
        pos = {r_r, r_c};
        interior = (r_p >= PW'(2)) && (r_r != '0) && (r_w + HW'(1) < hgt)
                   && (r_c != '0) && (c_w + WW'(1) < wid);
        end_row = (c_w + WW'(1) >= wid);
        end_plane = end_row && (r_w + HW'(1) >= hgt);
        end_grid = end_plane && (p_w + DW'(1) >= dep);
        idx_full = ((32'(p_w) - 32'd1) * 32'(hgt) + 32'(r_w)) * 32'(wid) + 32'(c_w);
        accept = i_valid && !o_stall;
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_eta[r_eta_nb][pos] <= i_eta_val;
            r_force[r_nb][pos]   <= i_force_req;
            r_grad[r_nb][pos]    <= i_pressure_grad;
            r_perm[r_nb][pos]    <= i_permeability;
            r_zeta[r_nb][pos]    <= i_zeta_val;
            r_vel[r_nb][pos]     <= i_velocity;
        end
        // The read states S_R0 and S_R1 gather the stencil from the centre and back plane banks.
        case (r_state)
            S_R0: begin
                r_rd_a <= r_force[!r_nb][r_pos];
                r_rd_b <= r_grad[!r_nb][r_pos];
                r_rd_k <= r_perm[!r_nb][r_pos];
                r_rd_c <= r_vel[!r_nb][r_pos];
                r_rd_d <= r_zeta[!r_nb][r_pos];
                r_rd_e <= r_eta[r_eta_cb][r_pos];
                r_rd_f <= r_eta[r_eta_bb][r_pos];
            end
            S_R1: begin
                r_work.force_v <= r_rd_a;
                r_work.grad_v  <= r_rd_b;
                r_work.perm_v  <= r_rd_k;
                r_work.vel_c   <= r_rd_c;
                r_work.zeta_c  <= r_rd_d;
                r_work.eta_c   <= r_rd_e;
                r_work.eta_p   <= r_rd_f;
                r_work.eta_n   <= r_eta_in;
                r_work.vel_n   <= r_vel[!r_nb][r_pos + AW'(1)];
                r_work.vel_p   <= r_vel[!r_nb][r_pos - AW'(1)];
                r_work.zeta_n  <= r_zeta[!r_nb][r_pos + AW'(MAX_WIDTH_P2)];
                r_work.zeta_p  <= r_zeta[!r_nb][r_pos - AW'(MAX_WIDTH_P2)];
                r_work.index   <= r_index;
                r_work.last    <= r_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_p      <= '0;
            r_r      <= '0;
            r_c      <= '0;
            r_nb     <= 1'b0;
            r_eta_nb <= 2'd0;
            r_eta_cb <= 2'd1;
            r_eta_bb <= 2'd2;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_restart) begin
                        r_p <= '0;
                        r_r <= '0;
                        r_c <= '0;
                    end else if (accept) begin
                        r_pos    <= pos;
                        r_index  <= idx_full[21:0];
                        r_last   <= (p_w + DW'(1) == dep) && (r_w + HW'(2) == hgt)
                                    && (c_w + WW'(2) == wid);
                        r_eta_in <= i_eta_val;
                        if (interior) begin
                            r_state <= S_R0;
                        end
                        if (end_row) begin
                            r_c <= '0;
                            if (end_plane) begin
                                r_r <= '0;
                                r_p <= end_grid ? '0 : r_p + PW'(1);
                                r_nb <= !r_nb;
                                r_eta_bb <= r_eta_cb;
                                r_eta_cb <= r_eta_nb;
                                r_eta_nb <= r_eta_bb;
                            end else begin
                                r_r <= r_r + RW'(1);
                            end
                        end else begin
                            r_c <= r_c + CW'(1);
                        end
                    end
                end
                S_R0: r_state <= S_R1;
                S_R1: r_state <= S_OUT;
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_work  = r_work;
endmodule

/* hw/rtl/vsft_queue.sv */
// Two-entry queue that decouples the front part from the back part.
`timescale 1ns / 1ps
module vsft_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  vsft_pkg::t_work i_work,
    output logic            o_valid,
    input  logic            i_stall,
    output vsft_pkg::t_work o_work
);
    vsft_pkg::t_work r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_work  = r_mem[r_rp];
    assign push = i_valid && !o_stall;
    assign pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* hw/rtl/vsft_back.sv */
// Back part: divides, multiplies and saturates one stencil into a g value.
`timescale 1ns / 1ps
module vsft_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [30:0]        i_visc,
    input  logic [30:0]        i_inv_dx2,
    input  logic [30:0]        i_inv_dy2,
    input  logic [30:0]        i_inv_dz2,
    input  logic               i_valid,
    output logic               o_stall,
    input  vsft_pkg::t_work    i_work,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_g_value,
    output logic [21:0]        o_point_index,
    output logic               o_last_point,
    output logic               o_saturated,
    output logic               o_div_fault
);
    typedef enum logic [2:0] {S_IDLE, S_DIV, S_DIFF, S_MUL, S_SUM, S_VISC, S_G, S_OUT}
        t_state;

    t_state r_state;
    vsft_pkg::t_work r_w;
    logic [5:0]  r_cnt;
    logic [47:0] r_rem;
    logic [47:0] r_quo;
    logic [31:0] r_den;
    logic        r_sat, r_fault;
    logic signed [31:0] r_coef, r_dx, r_dy, r_dz, r_tx, r_ty, r_tz, r_lap, r_damp, r_visc;

    logic [48:0] rem_try;
    logic [32:0] s0, s1, s2, s3, s4, s5, s6, s7, s8;
    logic signed [63:0] px, py, pz, pd, pv;
    logic signed [63:0] gsum;
    logic [32:0] g_sat;

    always_comb begin
        rem_try = {r_rem, r_quo[47]} - {17'd0, r_den};
        s0 = vsft_pkg::sat32(64'(r_w.eta_n) - 64'(r_w.eta_c) * 2 + 64'(r_w.eta_p));
        s1 = vsft_pkg::sat32(64'(r_w.zeta_n) - 64'(r_w.zeta_c) * 2 + 64'(r_w.zeta_p));
        s2 = vsft_pkg::sat32(64'(r_w.vel_n) - 64'(r_w.vel_c) * 2 + 64'(r_w.vel_p));
        px = r_dx * $signed({1'b0, i_inv_dx2});
        py = r_dy * $signed({1'b0, i_inv_dy2});
        pz = r_dz * $signed({1'b0, i_inv_dz2});
        s3 = vsft_pkg::sat32(px >>> 16);
        s4 = vsft_pkg::sat32(py >>> 16);
        s5 = vsft_pkg::sat32(pz >>> 16);
        s6 = vsft_pkg::sat32(64'(r_tx) + 64'(r_ty) + 64'(r_tz));
        pd = r_coef * r_w.vel_c;
        pv = r_lap * $signed({1'b0, i_visc});
        s7 = vsft_pkg::sat32(pd >>> 16);
        s8 = vsft_pkg::sat32(pv >>> 17);
        gsum = 64'(r_w.force_v) - 64'(r_w.grad_v) - 64'(r_damp) + 64'(r_visc);
        g_sat = vsft_pkg::sat32(gsum);
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_w     <= i_work;
                        r_rem   <= '0;
                        r_quo   <= {i_visc, 17'd0} >> 1;
                        r_den   <= {i_work.perm_v, 1'b0};
                        r_cnt   <= 6'd0;
                        r_sat   <= 1'b0;
                        r_fault <= (i_work.perm_v == 31'd0);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    if (rem_try[48]) begin
                        r_rem <= {r_rem[46:0], r_quo[47]};
                        r_quo <= {r_quo[46:0], 1'b0};
                    end else begin
                        r_rem <= rem_try[47:0];
                        r_quo <= {r_quo[46:0], 1'b1};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd47) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    if (r_fault) begin
                        r_coef <= 32'sh7FFF_FFFF;
                    end else if (r_quo[47:31] != '0) begin
                        r_coef <= 32'sh7FFF_FFFF;
                    end else begin
                        r_coef <= $signed({1'b0, r_quo[30:0]});
                    end
                    r_dx <= s0[31:0];
                    r_dy <= s1[31:0];
                    r_dz <= s2[31:0];
                    r_sat <= r_sat | s0[32] | s1[32] | s2[32]
                             | (!r_fault && (r_quo[47:31] != '0));
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_tx <= s3[31:0];
                    r_ty <= s4[31:0];
                    r_tz <= s5[31:0];
                    r_sat <= r_sat | s3[32] | s4[32] | s5[32];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_lap  <= s6[31:0];
                    r_damp <= s7[31:0];
                    r_sat  <= r_sat | s6[32] | s7[32];
                    r_state <= S_VISC;
                end
                S_VISC: begin
                    r_visc <= s8[31:0];
                    r_sat  <= r_sat | s8[32];
                    r_state <= S_G;
                end
                S_G: begin
                    o_g_value     <= g_sat[31:0];
                    o_saturated   <= r_sat | g_sat[32];
                    o_point_index <= r_w.index;
                    o_last_point  <= r_w.last;
                    o_div_fault   <= r_fault;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* hw/rtl/viscous_stencil_force_term.sv */
// Top level of the viscous stencil force term block.
`timescale 1ns / 1ps
// Use: grid points of one velocity component arrive in row-major order
// (plane, row, column) on the input channel, one transfer per point, with
// valid and stall. The block buffers whole planes and, one plane behind the
// input, gives one result transfer for each interior centre point; boundary
// points give none. Results leave on the output channel with valid and stall.
// Configuration is a plain write port (enable, index, data) used only while
// the block is idle; writing a geometry register restarts the grid.
// A point that gives no result is taken without holding the input. A point
// that gives a result holds the front part through the states S_R0, S_R1 and
// S_OUT while it reads its stencil from the plane buffers; the back part then
// runs its bit-serial 48-step divider for nu/(2k) and takes no new stencil
// until its result has left on the output channel.
// Reset (synchronous, active low) clears the counters, control state and
// registers to their defaults; the plane buffers are not cleared, since every
// entry is written before it is read. A stalled receiver holds the result;
// the two-entry queue then fills and the front part stalls its input.
module viscous_stencil_force_term #(
    parameter int MAX_DEPTH  = vsft_pkg::MAX_DEPTH_DEF,
    parameter int MAX_HEIGHT = vsft_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = vsft_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vsft_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vsft_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [31:0]              i_force_req,
    input  logic signed [31:0]              i_pressure_grad,
    input  logic [30:0]                     i_permeability,
    input  logic signed [31:0]              i_eta_val,
    input  logic signed [31:0]              i_zeta_val,
    input  logic signed [31:0]              i_velocity,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [31:0]              o_g_value,
    output logic [21:0]                     o_point_index,
    output logic                            o_last_point,
    output logic                            o_saturated,
    output logic                            o_div_fault
);
    logic [30:0] r_visc, r_inv_dx2, r_inv_dy2, r_inv_dz2;
    logic [10:0] r_depth;
    logic [6:0]  r_height, r_width;
    logic        restart;

    // Geometry writes restart the grid walk in the front part.
    assign restart = i_cfg_we && (i_cfg_index == vsft_pkg::REG_DEPTH
                     || i_cfg_index == vsft_pkg::REG_HEIGHT
                     || i_cfg_index == vsft_pkg::REG_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visc    <= 31'd65536;
            r_inv_dx2 <= 31'd65536;
            r_inv_dy2 <= 31'd65536;
            r_inv_dz2 <= 31'd65536;
            r_depth   <= 11'd3;
            r_height  <= 7'd3;
            r_width   <= 7'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vsft_pkg::REG_VISCOSITY: r_visc    <= i_cfg_data;
                vsft_pkg::REG_INV_DX2:   r_inv_dx2 <= i_cfg_data;
                vsft_pkg::REG_INV_DY2:   r_inv_dy2 <= i_cfg_data;
                vsft_pkg::REG_INV_DZ2:   r_inv_dz2 <= i_cfg_data;
                vsft_pkg::REG_DEPTH:     r_depth   <= i_cfg_data[10:0];
                vsft_pkg::REG_HEIGHT:    r_height  <= i_cfg_data[6:0];
                vsft_pkg::REG_WIDTH:     r_width   <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    logic            f_valid, q_stall, q_valid, b_stall;
    vsft_pkg::t_work f_work, q_work;

    vsft_front #(
        .MAX_DEPTH (MAX_DEPTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (restart),
        .i_depth        (r_depth),
        .i_height       (r_height),
        .i_width        (r_width),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_force_req    (i_force_req),
        .i_pressure_grad(i_pressure_grad),
        .i_permeability (i_permeability),
        .i_eta_val      (i_eta_val),
        .i_zeta_val     (i_zeta_val),
        .i_velocity     (i_velocity),
        .o_valid        (f_valid),
        .i_stall        (q_stall),
        .o_work         (f_work)
    );

    vsft_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(f_valid),
        .o_stall(q_stall),
        .i_work (f_work),
        .o_valid(q_valid),
        .i_stall(b_stall),
        .o_work (q_work)
    );

    vsft_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_visc       (r_visc),
        .i_inv_dx2    (r_inv_dx2),
        .i_inv_dy2    (r_inv_dy2),
        .i_inv_dz2    (r_inv_dz2),
        .i_valid      (q_valid),
        .o_stall      (b_stall),
        .i_work       (q_work),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_g_value    (o_g_value),
        .o_point_index(o_point_index),
        .o_last_point (o_last_point),
        .o_saturated  (o_saturated),
        .o_div_fault  (o_div_fault)
    );
endmodule

/* tb/tb_viscous_stencil_force_term.sv */
// Self-checking testbench for the viscous stencil force term block.
`timescale 1ns / 1ps
module tb_viscous_stencil_force_term;
    // Index that no register answers to; a write to it must change nothing.
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int ROW_PITCH = 64;
    localparam int PLANE_WORDS = 64 * 64;

    typedef struct {
        logic signed [31:0] frc;
        logic signed [31:0] grad;
        logic [30:0]        perm;
        logic signed [31:0] eta;
        logic signed [31:0] zeta;
        logic signed [31:0] vel;
    } t_point;

    typedef struct {
        logic signed [31:0] g;
        logic [21:0]        idx;
        logic               last;
        logic               sat;
        logic               fault;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [30:0] i_cfg_data = '0;
    logic tx_valid = 1'b0;
    logic rx_stall = 1'b0;
    t_point tx_pt = '{default: '0};
    logic o_stall, o_valid, o_last_point, o_saturated, o_div_fault;
    logic signed [31:0] o_g_value;
    logic [21:0] o_point_index;

    always #5 i_clk = ~i_clk;

    viscous_stencil_force_term DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(tx_valid), .o_stall(o_stall),
        .i_force_req(tx_pt.frc), .i_pressure_grad(tx_pt.grad),
        .i_permeability(tx_pt.perm), .i_eta_val(tx_pt.eta),
        .i_zeta_val(tx_pt.zeta), .i_velocity(tx_pt.vel),
        .o_valid(o_valid), .i_stall(rx_stall),
        .o_g_value(o_g_value), .o_point_index(o_point_index),
        .o_last_point(o_last_point), .o_saturated(o_saturated),
        .o_div_fault(o_div_fault)
    );

    t_point pending_pts[$];
    t_result expected_forces[$];
    int errors = 0;
    int forces_seen = 0;
    int cyc = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit sender_paused = 1'b0;

    // Shadow of the block's registers, counters and plane buffers.
    logic [30:0] nu, inv_x, inv_y, inv_z;
    logic [10:0] depth_r;
    logic [6:0] height_r, width_r;
    int cnt_plane, cnt_row, cnt_col;
    logic signed [31:0] eta_back[PLANE_WORDS], eta_ctr[PLANE_WORDS], eta_nx[PLANE_WORDS];
    logic signed [31:0] frc_p[PLANE_WORDS], frc_nx[PLANE_WORDS];
    logic signed [31:0] grad_p[PLANE_WORDS], grad_nx[PLANE_WORDS];
    logic [30:0] perm_p[PLANE_WORDS], perm_nx[PLANE_WORDS];
    logic signed [31:0] zeta_p[PLANE_WORDS], zeta_nx[PLANE_WORDS];
    logic signed [31:0] vel_p[PLANE_WORDS], vel_nx[PLANE_WORDS];

    // The idle-free window: neither side pauses at random while the cycle count is in it.
    function automatic bit quiet();
        return cyc >= 1000 && cyc < 2500;
    endfunction

    function automatic longint clip_q(longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic int dim_eff(int v, int hi);
        if (v < 3) return 3;
        return (v > hi) ? hi : v;
    endfunction

    // Second difference scaled by an inverse grid spacing squared, Q16.16.
    function automatic longint scaled_d2(longint a, longint b, longint c, logic [30:0] inv,
                                         inout bit flag);
        longint d;
        d = clip_q(a - 2 * b + c, flag);
        return clip_q((d * longint'(inv)) >>> 16, flag);
    endfunction

    // Accounts for one accepted grid point and queues the force term it produces.
    function automatic void step_stencil(t_point pt);
        int dep, hgt, wid, p, r, c, pos;
        bit sat_f, fault_f;
        longint f, gr, sp, coef, damp, lap, visc, g;
        longint unsigned k;
        t_result res;
        dep = dim_eff(depth_r, 1024);
        hgt = dim_eff(height_r, 64);
        wid = dim_eff(width_r, 64);
        p = cnt_plane;
        r = cnt_row;
        c = cnt_col;
        if (p >= dep || r >= hgt || c >= wid) begin
            p = 0;
            r = 0;
            c = 0;
        end
        pos = r * ROW_PITCH + c;
        if (p >= 2 && r >= 1 && r + 1 < hgt && c >= 1 && c + 1 < wid) begin
            sat_f = 1'b0;
            fault_f = 1'b0;
            f = frc_p[pos];
            gr = grad_p[pos];
            sp = vel_p[pos];
            k = perm_p[pos];
            if (k == 0) begin
                fault_f = 1'b1;
                coef = 64'sd2147483647;
            end else begin
                coef = longint'((longint'(nu) << 16) / (2 * k));
                coef = clip_q(coef, sat_f);
            end
            damp = clip_q((coef * sp) >>> 16, sat_f);
            lap = scaled_d2(pt.eta, eta_ctr[pos], eta_back[pos], inv_x, sat_f);
            lap += scaled_d2(zeta_p[pos + ROW_PITCH], zeta_p[pos], zeta_p[pos - ROW_PITCH],
                             inv_y, sat_f);
            lap += scaled_d2(vel_p[pos + 1], sp, vel_p[pos - 1], inv_z, sat_f);
            lap = clip_q(lap, sat_f);
            visc = clip_q((longint'(nu) * lap) >>> 17, sat_f);
            g = clip_q(f - gr - damp + visc, sat_f);
            res.g = g[31:0];
            res.idx = 22'(((p - 1) * hgt + r) * wid + c);
            res.last = (p == dep - 1 && r == hgt - 2 && c == wid - 2);
            res.sat = sat_f;
            res.fault = fault_f;
            expected_forces.push_back(res);
        end
        eta_nx[pos] = pt.eta;
        frc_nx[pos] = pt.frc;
        grad_nx[pos] = pt.grad;
        perm_nx[pos] = pt.perm;
        zeta_nx[pos] = pt.zeta;
        vel_nx[pos] = pt.vel;
        c++;
        if (c >= wid) begin
            c = 0;
            r++;
            if (r >= hgt) begin
                r = 0;
                eta_back = eta_ctr;
                eta_ctr = eta_nx;
                frc_p = frc_nx;
                grad_p = grad_nx;
                perm_p = perm_nx;
                zeta_p = zeta_nx;
                vel_p = vel_nx;
                p++;
                if (p >= dep) p = 0;
            end
        end
        cnt_plane = p;
        cnt_row = r;
        cnt_col = c;
    endfunction

    // Sender: a new point is offered only when the previous one has been taken.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (i_rst_n) begin
            if (tx_valid && !o_stall) step_stencil(tx_pt);
            if (!tx_valid || !o_stall) begin
                if (pending_pts.size() != 0 && !sender_paused
                    && (quiet() || $urandom_range(0, 99) >= 23)) begin
                    tx_pt <= pending_pts.pop_front();
                    tx_valid <= 1'b1;
                end else begin
                    tx_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transfer and decides the stall for the next cycle.
    always @(posedge i_clk) begin
        t_result exp_f;
        if (i_rst_n) begin
            if (o_valid && !rx_stall) begin
                forces_seen++;
                if (expected_forces.size() == 0) begin
                    $error("unexpected result transfer, index %0d", o_point_index);
                    errors++;
                end else begin
                    exp_f = expected_forces.pop_front();
                    if (o_g_value !== exp_f.g) begin
                        $error("g_value: expected %0d, got %0d", exp_f.g, o_g_value);
                        errors++;
                    end
                    if (o_point_index !== exp_f.idx) begin
                        $error("point_index: expected %0d, got %0d", exp_f.idx, o_point_index);
                        errors++;
                    end
                    if (o_last_point !== exp_f.last) begin
                        $error("last_point: expected %0b, got %0b", exp_f.last, o_last_point);
                        errors++;
                    end
                    if (o_saturated !== exp_f.sat) begin
                        $error("saturated: expected %0b, got %0b", exp_f.sat, o_saturated);
                        errors++;
                    end
                    if (o_div_fault !== exp_f.fault) begin
                        $error("div_fault: expected %0b, got %0b", exp_f.fault, o_div_fault);
                        errors++;
                    end
                end
            end
            // A long hold-off from the ninth result on, over the deep grid, so that the result queue
            // fills and the front part has to stall its input.
            if (forces_seen == 9 && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= 900;
                rx_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                rx_stall <= 1'b1;
            end else begin
                rx_stall <= !quiet() && $urandom_range(0, 99) < 23;
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0000;
                    default: return 32'h0001_0000;
                endcase
            end
            default: return 32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
        endcase
    endfunction

    function automatic t_point random_point();
        t_point pt;
        logic [31:0] kw;
        pt.frc = pick_word();
        pt.grad = pick_word();
        pt.eta = pick_word();
        pt.zeta = pick_word();
        pt.vel = pick_word();
        // Zero permeability is made common enough to hit the divide fault often.
        kw = pick_word();
        pt.perm = ($urandom_range(0, 9) == 0) ? 31'd0 : kw[30:0];
        return pt;
    endfunction

    task automatic add_points(int n);
        repeat (n) pending_pts.push_back(random_point());
    endtask

    task automatic wait_idle();
        while (pending_pts.size() != 0 || tx_valid || expected_forces.size() != 0)
            @(posedge i_clk);
        // A boundary point may still be in flight after the last result.
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [30:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            vsft_pkg::REG_VISCOSITY: nu = data;
            vsft_pkg::REG_INV_DX2:   inv_x = data;
            vsft_pkg::REG_INV_DY2:   inv_y = data;
            vsft_pkg::REG_INV_DZ2:   inv_z = data;
            vsft_pkg::REG_DEPTH:     depth_r = data[10:0];
            vsft_pkg::REG_HEIGHT:    height_r = data[6:0];
            vsft_pkg::REG_WIDTH:     width_r = data[6:0];
            default: ;
        endcase
        if (idx == vsft_pkg::REG_DEPTH || idx == vsft_pkg::REG_HEIGHT
            || idx == vsft_pkg::REG_WIDTH) begin
            cnt_plane = 0;
            cnt_row = 0;
            cnt_col = 0;
        end
    endtask

    task automatic set_all(logic [30:0] v, logic [30:0] ix, logic [30:0] iy,
                           logic [30:0] iz, int d, int h, int w);
        wait_idle();
        write_reg(vsft_pkg::REG_VISCOSITY, v);
        write_reg(vsft_pkg::REG_INV_DX2, ix);
        write_reg(vsft_pkg::REG_INV_DY2, iy);
        write_reg(vsft_pkg::REG_INV_DZ2, iz);
        write_reg(vsft_pkg::REG_DEPTH, 31'(d));
        write_reg(vsft_pkg::REG_HEIGHT, 31'(h));
        write_reg(vsft_pkg::REG_WIDTH, 31'(w));
    endtask

    function automatic logic [30:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 31'h7FFF_FFFF;
            1: return 31'd0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(1024, 4 * 65536));
        endcase
    endfunction

    initial begin
        t_point pt;
        int fed, d, h, w, n;
        bit paused_once;
        nu = 31'd65536;
        inv_x = 31'd65536;
        inv_y = 31'd65536;
        inv_z = 31'd65536;
        depth_r = 11'd3;
        height_r = 7'd3;
        width_r = 7'd3;
        cnt_plane = 0;
        cnt_row = 0;
        cnt_col = 0;
        paused_once = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed grid at reset geometry: extreme values everywhere and zero
        // permeability at the one interior centre.
        for (int i = 0; i < 27; i++) begin
            pt.frc = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            pt.grad = (i % 3 == 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            pt.perm = (i == 13) ? 31'd0 : ((i % 2) ? 31'h7FFF_FFFF : 31'd1);
            pt.eta = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            pt.zeta = (i % 4 < 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            pt.vel = (i % 3 == 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            pending_pts.push_back(pt);
        end

        // An unknown index must be ignored; then extremes of every register.
        wait_idle();
        write_reg(REG_UNUSED, 31'h7FFF_FFFF);
        add_points(27);
        set_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 1, 2);
        add_points(54);
        set_all(31'd0, 31'd0, 31'd0, 31'd0, 3, 3, 3);
        add_points(27);
        // Oversized height and width are held at their maximum; two planes and the
        // start of a third are enough to reach the first interior centres.
        set_all(31'd65536, 31'd32768, 31'd65536, 31'd131072, 3, 127, 3);
        add_points(2 * 64 * 3 + 3 * 3);
        set_all(31'd98304, 31'd65536, 31'd16384, 31'd65536, 3, 3, 100);
        add_points(2 * 3 * 64 + 64 + 3);
        // The largest depth, fed only partly before the geometry is rewritten.
        set_all(31'd65536, 31'd65536, 31'd65536, 31'd65536, 2047, 3, 4);
        add_points(12 * 6);

        fed = 0;
        while (fed < 250) begin
            d = $urandom_range(3, 4);
            h = $urandom_range(3, 5);
            w = $urandom_range(3, 5);
            set_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), d, h, w);
            // Runs past the end of the grid so that the counters wrap.
            n = d * h * w * $urandom_range(1, 2) + $urandom_range(0, 2) * h * w;
            add_points(n);
            fed += n;
            if (!paused_once) begin
                // Hold the sender until every queued force term has come back.
                paused_once = 1'b1;
                while (pending_pts.size() != 0 || tx_valid) @(posedge i_clk);
                sender_paused = 1'b1;
                while (expected_forces.size() != 0) @(posedge i_clk);
                sender_paused = 1'b0;
                add_points(h * w * 2);
                fed += h * w * 2;
            end
        end

        while (pending_pts.size() != 0 || tx_valid || expected_forces.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
